/* sv/ccl_pkg.sv */
// Shared types and constants for the clean component leakage model.
`timescale 1ns / 1ps
package ccl_pkg;

  // Operation codes carried by in_op
  localparam logic [1:0] OP_LOAD_COMP = 2'd0;
  localparam logic [1:0] OP_LOAD_BEAM = 2'd1;
  localparam logic [1:0] OP_SAMPLE    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RADIUS      = 3'd0;
  localparam logic [2:0] CFG_PEAK_COL    = 3'd1;
  localparam logic [2:0] CFG_PEAK_ROW    = 3'd2;
  localparam logic [2:0] CFG_COL_SCALE   = 3'd3;
  localparam logic [2:0] CFG_ROW_SCALE   = 3'd4;
  localparam logic [2:0] CFG_BEAM_COLS   = 3'd5;
  localparam logic [2:0] CFG_GAUSS_SCALE = 3'd6;

  // Field widths
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 11;
  localparam int WORD_W  = 18;
  localparam int FLUX_W  = 24;
  localparam int PROD_W  = 42;
  localparam int QUO_W   = 33;

  // Divide-by-1000 unit: four 11-bit digits per division
  localparam int DIV_STEPS = 4;
  localparam int DIV_DIG   = 11;

  typedef enum logic [3:0] {
    ST_BUILD,
    ST_IDLE,
    ST_RDC,
    ST_MATCH,
    ST_MUL,
    ST_PIX,
    ST_ADDR,
    ST_BRD,
    ST_ERD,
    ST_PROD,
    ST_DIVS,
    ST_DIVW,
    ST_ACCB,
    ST_ACCG,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_sample;
    logic build_step;
    logic rd_comp;
    logic lat_match;
    logic lat_mul;
    logic lat_pix;
    logic lat_addr;
    logic lat_brd;
    logic lat_erd;
    logic lat_prod;
    logic div_start;
    logic acc_beam;
    logic acc_gauss;
    logic next_comp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic build_last;
    logic match;
    logic last_comp;
    logic count_zero;
    logic div_done;
  } sts_t;

endpackage

/* sv/ccl_div1000.sv */
// Digit-serial signed divide by 1000, rounding half away from zero.
`timescale 1ns / 1ps
module ccl_div1000 (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ccl_pkg::PROD_W-1:0]    prod,
  output logic signed [ccl_pkg::QUO_W-1:0]     quo,
  output logic                                 done
);
  import ccl_pkg::*;

  localparam int XW = DIV_STEPS * DIV_DIG;

  logic          busy_r;
  logic [1:0]    step_r;
  logic          neg_r;
  logic [XW-1:0] x_r;
  logic [XW-1:0] q_r;
  logic [9:0]    rem_r;

  logic [PROD_W-1:0] mag;
  logic [20:0]       v;
  logic [32:0]       est_p;
  logic [10:0]       est;
  logic [21:0]       r0;
  logic [10:0]       qd;
  logic [9:0]        rem_nxt;
  logic signed [QUO_W-1:0] q_s;

  // Magnitude of the incoming product
  assign mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  // One decimal-free digit step: quotient estimate by reciprocal, then correct
  always_comb begin
    v     = {rem_r, x_r[XW-1 -: DIV_DIG]};
    est_p = 33'(v) * 33'd2097;
    est   = est_p[31:21];
    r0    = 22'(v) - 22'(est) * 22'd1000;
    if (r0 >= 22'd1000) begin
      rem_nxt = 10'(r0 - 22'd1000);
      qd      = est + 11'd1;
    end else begin
      rem_nxt = r0[9:0];
      qd      = est;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 2'd0;
    end else if (busy_r) begin
      step_r <= step_r + 2'd1;
      if (step_r == 2'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Hold the operand and shift in one quotient digit per step
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= prod[PROD_W-1];
      x_r   <= XW'(mag) + XW'(500);
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      x_r   <= x_r << DIV_DIG;
      q_r   <= {q_r[XW-DIV_DIG-1:0], qd};
      rem_r <= rem_nxt;
    end
  end

  assign q_s  = $signed({1'b0, q_r[QUO_W-2:0]});
  assign quo  = neg_r ? -q_s : q_s;
  assign done = !busy_r;

endmodule

/* sv/ccl_ctrl.sv */
// Sequencer for table build, loads and the per-component sample walk.
`timescale 1ns / 1ps
module ccl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_op,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ccl_pkg::sts_t  sts,
  output ccl_pkg::cmd_t  cmd
);
  import ccl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_BUILD: if (sts.build_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid && in_op == OP_SAMPLE) begin
          state_nxt = sts.count_zero ? ST_DONE : ST_RDC;
        end
      end
      ST_RDC:   state_nxt = ST_MATCH;
      ST_MATCH: begin
        if (sts.match) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = sts.last_comp ? ST_DONE : ST_RDC;
        end
      end
      ST_MUL:   state_nxt = ST_PIX;
      ST_PIX:   state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_BRD;
      ST_BRD:   state_nxt = ST_ERD;
      ST_ERD:   state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_DIVS;
      ST_DIVS:  state_nxt = ST_DIVW;
      ST_DIVW:  if (sts.div_done) state_nxt = ST_ACCB;
      ST_ACCB:  state_nxt = ST_ACCG;
      ST_ACCG:  state_nxt = sts.last_comp ? ST_DONE : ST_RDC;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.out_load = out_load;
    unique case (state_r)
      ST_BUILD: cmd.build_step = 1'b1;
      ST_IDLE: begin
        cmd.accept       = in_valid;
        cmd.start_sample = in_valid && in_op == OP_SAMPLE;
      end
      ST_RDC:   cmd.rd_comp = 1'b1;
      ST_MATCH: begin
        cmd.lat_match = 1'b1;
        cmd.next_comp = !sts.match;
      end
      ST_MUL:   cmd.lat_mul = 1'b1;
      ST_PIX:   cmd.lat_pix = 1'b1;
      ST_ADDR:  cmd.lat_addr = 1'b1;
      ST_BRD:   cmd.lat_brd = 1'b1;
      ST_ERD:   cmd.lat_erd = 1'b1;
      ST_PROD:  cmd.lat_prod = 1'b1;
      ST_DIVS:  cmd.div_start = 1'b1;
      ST_ACCB:  cmd.acc_beam = 1'b1;
      ST_ACCG: begin
        cmd.acc_gauss = 1'b1;
        cmd.next_comp = 1'b1;
      end
      default: cmd = cmd;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUILD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/ccl_dp.sv */
// Datapath: configuration, stores, exponential table and Stokes accumulators.
`timescale 1ns / 1ps
module ccl_dp #(
  parameter int MAX_COMPONENTS  = 1024,
  parameter int BEAM_WORDS      = 65536,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ccl_pkg::cmd_t                       cmd,
  output ccl_pkg::sts_t                       sts,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_wdata,
  input  logic [1:0]                          in_op,
  input  logic signed [31:0]                  in_pos_ra,
  input  logic signed [31:0]                  in_pos_dec,
  input  logic signed [ccl_pkg::FLUX_W-1:0]   in_comp_flux,
  input  logic [15:0]                         in_beam_addr,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_i_word,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_q_word,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_u_word,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_v_word,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_i,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_q,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_u,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_v,
  output logic [ccl_pkg::CNT_W-1:0]           out_matched_count,
  output logic [ccl_pkg::CNT_W-1:0]           out_off_map_count
);
  import ccl_pkg::*;

  localparam int CW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int NW   = $clog2(MAX_COMPONENTS + 1);
  localparam int BW   = $clog2(BEAM_WORDS);
  localparam int EW   = $clog2(EXP_TABLE_DEPTH);
  localparam int EDW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SW   = 20 + EDW + 1;
  localparam int BMW  = 4 * WORD_W;

  // Decay ratio exp(-16/depth): 25-term series in Q58, rounded to Q32
  localparam logic [63:0] TB  = 64'd1 << 58;
  localparam logic [63:0] D64 = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] T01 = TB;
  localparam logic [63:0] U01 = (TB  * 64'd16) / (D64 * 64'd1);
  localparam logic [63:0] U02 = (U01 * 64'd16) / (D64 * 64'd2);
  localparam logic [63:0] U03 = (U02 * 64'd16) / (D64 * 64'd3);
  localparam logic [63:0] U04 = (U03 * 64'd16) / (D64 * 64'd4);
  localparam logic [63:0] U05 = (U04 * 64'd16) / (D64 * 64'd5);
  localparam logic [63:0] U06 = (U05 * 64'd16) / (D64 * 64'd6);
  localparam logic [63:0] U07 = (U06 * 64'd16) / (D64 * 64'd7);
  localparam logic [63:0] U08 = (U07 * 64'd16) / (D64 * 64'd8);
  localparam logic [63:0] U09 = (U08 * 64'd16) / (D64 * 64'd9);
  localparam logic [63:0] U10 = (U09 * 64'd16) / (D64 * 64'd10);
  localparam logic [63:0] U11 = (U10 * 64'd16) / (D64 * 64'd11);
  localparam logic [63:0] U12 = (U11 * 64'd16) / (D64 * 64'd12);
  localparam logic [63:0] U13 = (U12 * 64'd16) / (D64 * 64'd13);
  localparam logic [63:0] U14 = (U13 * 64'd16) / (D64 * 64'd14);
  localparam logic [63:0] U15 = (U14 * 64'd16) / (D64 * 64'd15);
  localparam logic [63:0] U16 = (U15 * 64'd16) / (D64 * 64'd16);
  localparam logic [63:0] U17 = (U16 * 64'd16) / (D64 * 64'd17);
  localparam logic [63:0] U18 = (U17 * 64'd16) / (D64 * 64'd18);
  localparam logic [63:0] U19 = (U18 * 64'd16) / (D64 * 64'd19);
  localparam logic [63:0] U20 = (U19 * 64'd16) / (D64 * 64'd20);
  localparam logic [63:0] U21 = (U20 * 64'd16) / (D64 * 64'd21);
  localparam logic [63:0] U22 = (U21 * 64'd16) / (D64 * 64'd22);
  localparam logic [63:0] U23 = (U22 * 64'd16) / (D64 * 64'd23);
  localparam logic [63:0] U24 = (U23 * 64'd16) / (D64 * 64'd24);
  localparam logic [63:0] SACC = T01 - U01 + U02 - U03 + U04 - U05 + U06 - U07 + U08
                               - U09 + U10 - U11 + U12 - U13 + U14 - U15 + U16 - U17
                               + U18 - U19 + U20 - U21 + U22 - U23 + U24;
  localparam logic [31:0] RATIO = 32'((SACC + (64'd1 << 25)) >> 26);

  // Configuration registers
  logic [23:0]        radius_r;
  logic [7:0]         peak_col_r;
  logic [7:0]         peak_row_r;
  logic signed [23:0] col_scale_r;
  logic signed [23:0] row_scale_r;
  logic [8:0]         beam_cols_r;
  logic [31:0]        gauss_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= 24'd139810;
      peak_col_r    <= 8'd128;
      peak_row_r    <= 8'd128;
      col_scale_r   <= 24'sd65536;
      row_scale_r   <= 24'sd65536;
      beam_cols_r   <= 9'd256;
      gauss_scale_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:      radius_r      <= cfg_wdata[23:0];
        CFG_PEAK_COL:    peak_col_r    <= cfg_wdata[7:0];
        CFG_PEAK_ROW:    peak_row_r    <= cfg_wdata[7:0];
        CFG_COL_SCALE:   col_scale_r   <= $signed(cfg_wdata[23:0]);
        CFG_ROW_SCALE:   row_scale_r   <= $signed(cfg_wdata[23:0]);
        CFG_BEAM_COLS:   beam_cols_r   <= cfg_wdata[8:0];
        CFG_GAUSS_SCALE: gauss_scale_r <= cfg_wdata;
        default:         radius_r      <= radius_r;
      endcase
    end
  end

  // Exponential table, filled by a sweep after reset
  logic [16:0]   exp_mem [EXP_TABLE_DEPTH];
  logic [EW-1:0] bk_r;
  logic [32:0]   c_r;
  logic [64:0]   c_prod;
  logic [33:0]   c_rnd;

  assign c_prod = 65'(c_r) * 65'(RATIO);
  assign c_rnd  = 34'(c_r) + 34'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_r <= '0;
      c_r  <= 33'd1 << 32;
    end else if (cmd.build_step) begin
      bk_r <= bk_r + EW'(1);
      c_r  <= c_prod[64:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_step) exp_mem[bk_r] <= c_rnd[32:16];
  end

  // Component stores
  logic signed [31:0]       comp_ra_mem   [MAX_COMPONENTS];
  logic signed [31:0]       comp_dec_mem  [MAX_COMPONENTS];
  logic signed [FLUX_W-1:0] comp_flux_mem [MAX_COMPONENTS];
  logic [NW-1:0]            count_r;
  logic [CW-1:0]            m_r;
  logic                     comp_wr;

  assign comp_wr = cmd.accept && in_op == OP_LOAD_COMP && count_r < NW'(MAX_COMPONENTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (comp_wr) begin
      count_r <= count_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (comp_wr) begin
      comp_ra_mem[count_r[CW-1:0]]   <= in_pos_ra;
      comp_dec_mem[count_r[CW-1:0]]  <= in_pos_dec;
      comp_flux_mem[count_r[CW-1:0]] <= in_comp_flux;
    end
  end

  // Beam planes, packed I Q U V
  logic [BMW-1:0] beam_mem [BEAM_WORDS];
  logic           beam_wr;

  assign beam_wr = cmd.accept && in_op == OP_LOAD_BEAM &&
                   21'(in_beam_addr) < 21'(BEAM_WORDS);

  always_ff @(posedge clk) begin
    if (beam_wr) begin
      beam_mem[BW'(in_beam_addr)] <= {in_beam_i_word, in_beam_q_word,
                                      in_beam_u_word, in_beam_v_word};
    end
  end

  // Sample position and component index
  logic signed [31:0] smp_ra_r, smp_dec_r;

  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      smp_ra_r  <= in_pos_ra;
      smp_dec_r <= in_pos_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= '0;
    end else if (cmd.start_sample) begin
      m_r <= '0;
    end else if (cmd.next_comp) begin
      m_r <= m_r + CW'(1);
    end
  end

  // Component read
  logic signed [31:0]       rd_ra_r, rd_dec_r;
  logic signed [FLUX_W-1:0] rd_flux_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_comp) begin
      rd_ra_r   <= comp_ra_mem[m_r];
      rd_dec_r  <= comp_dec_mem[m_r];
      rd_flux_r <= comp_flux_mem[m_r];
    end
  end

  // Window match on the offsets
  logic signed [32:0] dx_c, dy_c, rad_c;
  logic               match_c;
  logic signed [24:0] dx_r, dy_r;
  logic signed [FLUX_W-1:0] flux_r;

  assign dx_c    = {smp_ra_r[31], smp_ra_r} - {rd_ra_r[31], rd_ra_r};
  assign dy_c    = {smp_dec_r[31], smp_dec_r} - {rd_dec_r[31], rd_dec_r};
  assign rad_c   = $signed({9'd0, radius_r});
  assign match_c = (dx_c < rad_c) && (dx_c > -rad_c) && (dy_c < rad_c) && (dy_c > -rad_c);

  always_ff @(posedge clk) begin
    if (cmd.lat_match) begin
      dx_r   <= dx_c[24:0];
      dy_r   <= dy_c[24:0];
      flux_r <= rd_flux_r;
    end
  end

  // Scale products and squares
  logic signed [48:0] mcol_r, mrow_r;
  logic signed [49:0] sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (cmd.lat_mul) begin
      mcol_r <= dx_r * col_scale_r;
      mrow_r <= dy_r * row_scale_r;
      sqx_r  <= dx_r * dx_r;
      sqy_r  <= dy_r * dy_r;
    end
  end

  // Pixel coordinates, truncated toward zero, and squared distance
  logic signed [49:0] tcol, trow;
  logic [49:0]        tcol_m, trow_m;
  logic signed [14:0] qcol, qrow;
  logic signed [14:0] col_r, row_r;
  logic [48:0]        sqsum;
  logic [28:0]        d2_r;

  always_comb begin
    tcol   = $signed({6'd0, peak_col_r, 36'd0}) + {mcol_r[48], mcol_r};
    trow   = $signed({6'd0, peak_row_r, 36'd0}) + {mrow_r[48], mrow_r};
    tcol_m = tcol[49] ? 50'(-tcol) : 50'(tcol);
    trow_m = trow[49] ? 50'(-trow) : 50'(trow);
    qcol   = $signed({1'b0, tcol_m[49:36]});
    qrow   = $signed({1'b0, trow_m[49:36]});
    sqsum  = sqx_r[47:0] + sqy_r[47:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_pix) begin
      col_r <= tcol[49] ? -qcol : qcol;
      row_r <= trow[49] ? -qrow : qrow;
      d2_r  <= sqsum[48:20];
    end
  end

  // Pixel address, off-map test and exponent argument
  logic [23:0]   addr_w;
  logic          off_c;
  logic [BW-1:0] addr_r;
  logic          off_r;
  logic [60:0]   p_r;

  always_comb begin
    addr_w = 24'(row_r[13:0]) * 24'(beam_cols_r) + 24'(col_r[13:0]);
    off_c  = col_r[14] || row_r[14] ||
             ({1'b0, col_r[13:0]} >= 15'(beam_cols_r)) ||
             (addr_w >= 24'(BEAM_WORDS));
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_addr) begin
      addr_r <= addr_w[BW-1:0];
      off_r  <= off_c;
      p_r    <= 61'(gauss_scale_r) * 61'(d2_r);
    end
  end

  // Beam read, table index and counters
  logic [BMW-1:0] beam_rd_r;
  logic [SW-1:0]  s_lo, s_idx;
  logic [EW-1:0]  idx_r;
  logic           gz_r;
  logic [NW-1:0]  matched_r, offmap_r;

  always_comb begin
    s_lo  = SW'(p_r[19:0]) * SW'(EXP_TABLE_DEPTH);
    s_idx = SW'(p_r[39:20]) * SW'(EXP_TABLE_DEPTH) + (s_lo >> 20);
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_brd) begin
      beam_rd_r <= beam_mem[addr_r];
      idx_r     <= s_idx[20 +: EW];
      gz_r      <= (p_r[60:40] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= '0;
      offmap_r  <= '0;
    end else if (cmd.start_sample) begin
      matched_r <= '0;
      offmap_r  <= '0;
    end else if (cmd.lat_brd) begin
      matched_r <= matched_r + NW'(1);
      if (off_r) offmap_r <= offmap_r + NW'(1);
    end
  end

  // Table read
  logic [16:0] g_r;

  always_ff @(posedge clk) begin
    if (cmd.lat_erd) g_r <= exp_mem[idx_r];
  end

  // Flux products; drop beam terms off the map and the Gaussian past its limit
  logic signed [PROD_W-1:0] prod_r [5];
  logic signed [WORD_W-1:0] bw [4];

  always_comb begin
    bw[0] = $signed(beam_rd_r[4*WORD_W-1 -: WORD_W]);
    bw[1] = $signed(beam_rd_r[3*WORD_W-1 -: WORD_W]);
    bw[2] = $signed(beam_rd_r[2*WORD_W-1 -: WORD_W]);
    bw[3] = $signed(beam_rd_r[WORD_W-1 -: WORD_W]);
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_prod) begin
      for (int j = 0; j < 4; j++) begin
        prod_r[j] <= off_r ? '0 : PROD_W'(bw[j]) * PROD_W'(flux_r);
      end
      prod_r[4] <= gz_r ? '0 : PROD_W'($signed({1'b0, g_r})) * PROD_W'(flux_r);
    end
  end

  // Divide-by-1000 lanes: I Q U V beam terms and the Gaussian term
  logic signed [QUO_W-1:0] quo [5];
  logic [4:0]              lane_done;

  for (genvar l = 0; l < 5; l++) begin : g_lane
    ccl_div1000 u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.div_start),
      .prod  (prod_r[l]),
      .quo   (quo[l]),
      .done  (lane_done[l])
    );
  end

  // Saturating accumulation
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [QUO_W-1:0] b,
    input logic                    sub
  );
    logic signed [SUM_W:0] s;
    s = sub ? ({a[SUM_W-1], a} - (SUM_W+1)'(b)) : ({a[SUM_W-1], a} + (SUM_W+1)'(b));
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  logic signed [SUM_W-1:0] sum_r [4];

  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      for (int j = 0; j < 4; j++) sum_r[j] <= '0;
    end else if (cmd.acc_beam) begin
      for (int j = 0; j < 4; j++) sum_r[j] <= sat_add(sum_r[j], quo[j], 1'b0);
    end else if (cmd.acc_gauss) begin
      sum_r[0] <= sat_add(sum_r[0], quo[4], 1'b1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum_i         <= sum_r[0];
      out_sum_q         <= sum_r[1];
      out_sum_u         <= sum_r[2];
      out_sum_v         <= sum_r[3];
      out_matched_count <= CNT_W'(matched_r);
      out_off_map_count <= CNT_W'(offmap_r);
    end
  end

  // Status to the sequencer
  always_comb begin
    sts.build_last = (bk_r == EW'(EXP_TABLE_DEPTH - 1));
    sts.match      = match_c;
    sts.last_comp  = (NW'(m_r) + NW'(1)) == count_r;
    sts.count_zero = (count_r == '0);
    sts.div_done   = lane_done[0];
  end

endmodule

/* sv/clean_component_leakage_model_core.sv */
// Top level of the clean component leakage model.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | op, position, flux, beam address and words
//   out     | output    | out_valid / out_stall  | four Stokes sums, matched and off-map counts
//   cfg     | input     | cfg_we                 | cfg_index, cfg_wdata
//
// After reset the exponential table is filled, one entry a cycle; no item
// is taken meanwhile. A load is written into its store when it is accepted.
// A sample walks the stored components one at a time; a component inside the
// window also passes through the divide-by-1000 lanes (four digit steps).
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module clean_component_leakage_model_core #(
  parameter int MAX_COMPONENTS  = 1024,
  parameter int BEAM_WORDS      = 65536,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic signed [31:0]                  in_pos_ra,
  input  logic signed [31:0]                  in_pos_dec,
  input  logic signed [ccl_pkg::FLUX_W-1:0]   in_comp_flux,
  input  logic [15:0]                         in_beam_addr,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_i_word,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_q_word,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_u_word,
  input  logic signed [ccl_pkg::WORD_W-1:0]   in_beam_v_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_i,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_q,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_u,
  output logic signed [ccl_pkg::SUM_W-1:0]    out_sum_v,
  output logic [ccl_pkg::CNT_W-1:0]           out_matched_count,
  output logic [ccl_pkg::CNT_W-1:0]           out_off_map_count,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_wdata
);
  import ccl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  ccl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  ccl_dp #(
    .MAX_COMPONENTS  (MAX_COMPONENTS),
    .BEAM_WORDS      (BEAM_WORDS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_pos_ra         (in_pos_ra),
    .in_pos_dec        (in_pos_dec),
    .in_comp_flux      (in_comp_flux),
    .in_beam_addr      (in_beam_addr),
    .in_beam_i_word    (in_beam_i_word),
    .in_beam_q_word    (in_beam_q_word),
    .in_beam_u_word    (in_beam_u_word),
    .in_beam_v_word    (in_beam_v_word),
    .out_sum_i         (out_sum_i),
    .out_sum_q         (out_sum_q),
    .out_sum_u         (out_sum_u),
    .out_sum_v         (out_sum_v),
    .out_matched_count (out_matched_count),
    .out_off_map_count (out_off_map_count)
  );

endmodule
